// File: src/sle_pkg.sv
// Shared codes, widths and controller/datapath command types for the list engine.
package sle_pkg;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 6;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FIND   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

    // store read requests
    localparam logic [2:0] RD_NONE = 3'd0;  // no read
    localparam logic [2:0] RD_UP   = 3'd1;  // read ptr-1, write it back at ptr
    localparam logic [2:0] RD_DN   = 3'd2;  // read ptr, write it back at ptr-1
    localparam logic [2:0] RD_SCAN = 3'd3;  // read ptr for compare
    localparam logic [2:0] RD_POS  = 3'd4;  // read position-1

    // walk pointer updates
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_SIZE = 3'd1;
    localparam logic [2:0] PTR_POS  = 3'd2;
    localparam logic [2:0] PTR_ZERO = 3'd3;
    localparam logic [2:0] PTR_INC  = 3'd4;
    localparam logic [2:0] PTR_DEC  = 3'd5;

    // result payload sources
    localparam logic [1:0] EM_CODE = 2'd0;  // status only, data and where zero
    localparam logic [1:0] EM_HOLD = 2'd1;  // held element and its position
    localparam logic [1:0] EM_INS  = 2'd2;  // inserted value and position

    typedef struct packed {
        logic              take;
        logic [2:0]        ptr_op;
        logic [2:0]        rd_op;
        logic              wr_val;
        logic              cap;
        logic              hit;
        logic              hold_clr;
        logic              clr_size;
        logic              inc_size;
        logic              dec_size;
        logic              emit;
        logic [1:0]        emit_sel;
        logic [STAT_W-1:0] status;
        logic              last;
    } sle_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ins_bad;
        logic              full;
        logic              pos_bad;
        logic              up_done;
        logic              ptr_end;
        logic              match;
        logic              hold_valid;
        logic              slot_free;
    } sle_stat_t;

endpackage

// File: src/sle_if.sv
// Operation and result channel interfaces of the list engine.
interface sle_in_if;
    logic                              valid;
    logic                              ready;
    logic [sle_pkg::FUNC_W-1:0]        func;
    logic [sle_pkg::POS_W-1:0]         position;
    logic signed [sle_pkg::DATA_W-1:0] value;

    modport source (output valid, func, position, value, input ready);
    modport sink (input valid, func, position, value, output ready);
endinterface

interface sle_out_if;
    logic                              valid;
    logic                              ready;
    logic [sle_pkg::STAT_W-1:0]        status;
    logic signed [sle_pkg::DATA_W-1:0] data;
    logic [sle_pkg::POS_W-1:0]         where;
    logic [sle_pkg::COUNT_W-1:0]       count;
    logic                              is_empty;
    logic                              last;

    modport source (output valid, status, data, where, count, is_empty, last, input ready);
    modport sink (input valid, status, data, where, count, is_empty, last, output ready);
endinterface

// File: src/sle_datapath.sv
// List engine datapath: element store, count, walk pointer, hold and result registers.
module sle_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sle_pkg::FUNC_W-1:0]        func,
    input  logic [sle_pkg::POS_W-1:0]         position,
    input  logic signed [sle_pkg::DATA_W-1:0] value,
    input  sle_pkg::sle_cmd_t                 cmd,
    output sle_pkg::sle_stat_t                stat,
    sle_out_if.source                         result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = ((CNT_W > sle_pkg::POS_W) ? CNT_W : sle_pkg::POS_W) + 1;

    logic [sle_pkg::FUNC_W-1:0]        func_reg;
    logic [sle_pkg::POS_W-1:0]         pos_reg;
    logic signed [sle_pkg::DATA_W-1:0] val_reg;

    logic [CNT_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_addr_reg, pend_addr_next;
    logic             hold_valid_reg, hold_valid_next;

    logic signed [sle_pkg::DATA_W-1:0] hold_reg;
    logic [sle_pkg::POS_W-1:0]         hold_where_reg;
    logic signed [sle_pkg::DATA_W-1:0] rdata_reg;
    logic signed [sle_pkg::DATA_W-1:0] store_mem [CAPACITY];

    logic                              out_valid_reg, out_valid_next;
    logic [sle_pkg::STAT_W-1:0]        out_status_reg;
    logic signed [sle_pkg::DATA_W-1:0] out_data_reg;
    logic [sle_pkg::POS_W-1:0]         out_where_reg;
    logic [sle_pkg::COUNT_W-1:0]       out_count_reg;
    logic                              out_empty_reg;
    logic                              out_last_reg;

    logic [CMP_W-1:0] size_w, pos_w, ptr_w, ptr_m1_w, pos_m1_w, size_next_w;
    logic [IDX_W-1:0] rd_addr, pos_idx;
    logic             rd_en;
    logic             slot_free;

    // widen for compares and address math
    always_comb
    begin
        size_w      = CMP_W'(size_reg);
        pos_w       = CMP_W'(pos_reg);
        ptr_w       = CMP_W'(ptr_reg);
        ptr_m1_w    = ptr_w - CMP_W'(1);
        pos_m1_w    = pos_w - CMP_W'(1);
        size_next_w = CMP_W'(size_next);
        pos_idx     = pos_m1_w[IDX_W-1:0];
    end

    assign slot_free = !out_valid_reg || result.ready;

    // status back to the controller
    always_comb
    begin
        stat.func       = func_reg;
        stat.ins_bad    = (pos_reg == '0) || (pos_w > size_w + CMP_W'(1));
        stat.full       = size_w >= CMP_W'(CAPACITY);
        stat.pos_bad    = (pos_reg == '0) || (pos_w > size_w);
        stat.up_done    = (ptr_w + CMP_W'(1)) == pos_w;
        stat.ptr_end    = ptr_w >= size_w;
        stat.match      = (func_reg == sle_pkg::FN_DUMP) || (rdata_reg == val_reg);
        stat.hold_valid = hold_valid_reg;
        stat.slot_free  = slot_free;
    end

    // select read address and the shift write-back target
    always_comb
    begin
        rd_en          = 1'b1;
        rd_addr        = ptr_w[IDX_W-1:0];
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        case (cmd.rd_op)
            sle_pkg::RD_UP:
            begin
                rd_addr        = ptr_m1_w[IDX_W-1:0];
                pend_next      = 1'b1;
                pend_addr_next = ptr_w[IDX_W-1:0];
            end
            sle_pkg::RD_DN:
            begin
                rd_addr        = ptr_w[IDX_W-1:0];
                pend_next      = 1'b1;
                pend_addr_next = ptr_m1_w[IDX_W-1:0];
            end
            sle_pkg::RD_SCAN: rd_addr = ptr_w[IDX_W-1:0];
            sle_pkg::RD_POS:  rd_addr = pos_idx;
            default:          rd_en = 1'b0;
        endcase
    end

    // advance the walk pointer
    always_comb
    begin
        case (cmd.ptr_op)
            sle_pkg::PTR_SIZE: ptr_next = size_reg;
            sle_pkg::PTR_POS:  ptr_next = pos_w[CNT_W-1:0];
            sle_pkg::PTR_ZERO: ptr_next = '0;
            sle_pkg::PTR_INC:  ptr_next = ptr_reg + CNT_W'(1);
            sle_pkg::PTR_DEC:  ptr_next = ptr_reg - CNT_W'(1);
            default:           ptr_next = ptr_reg;
        endcase
    end

    // update element count
    always_comb
    begin
        if (cmd.clr_size)
            size_next = '0;
        else if (cmd.inc_size)
            size_next = size_reg + CNT_W'(1);
        else if (cmd.dec_size)
            size_next = size_reg - CNT_W'(1);
        else
            size_next = size_reg;
    end

    always_comb
    begin
        if (cmd.hold_clr)
            hold_valid_next = 1'b0;
        else if (cmd.hit)
            hold_valid_next = 1'b1;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= '0;
            ptr_reg        <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            size_reg       <= size_next;
            ptr_reg        <= ptr_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold operands, held element and result payload
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        if (cmd.take)
        begin
            func_reg <= func;
            pos_reg  <= position;
            val_reg  <= value;
        end
        if (cmd.cap)
        begin
            hold_reg       <= rdata_reg;
            hold_where_reg <= pos_reg;
        end
        else if (cmd.hit)
        begin
            hold_reg       <= rdata_reg;
            hold_where_reg <= ptr_w[sle_pkg::POS_W-1:0];
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.status;
            out_last_reg   <= cmd.last;
            out_count_reg  <= size_next_w[sle_pkg::COUNT_W-1:0];
            out_empty_reg  <= (size_next == '0);
            case (cmd.emit_sel)
                sle_pkg::EM_HOLD:
                begin
                    out_data_reg  <= hold_reg;
                    out_where_reg <= hold_where_reg;
                end
                sle_pkg::EM_INS:
                begin
                    out_data_reg  <= val_reg;
                    out_where_reg <= pos_reg;
                end
                default:
                begin
                    out_data_reg  <= '0;
                    out_where_reg <= '0;
                end
            endcase
        end
    end

    // element store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (pend_reg)
            store_mem[pend_addr_reg] <= rdata_reg;
        else if (cmd.wr_val)
            store_mem[pos_idx] <= val_reg;
        if (rd_en)
            rdata_reg <= store_mem[rd_addr];
    end

    assign result.valid    = out_valid_reg;
    assign result.status   = out_status_reg;
    assign result.data     = out_data_reg;
    assign result.where    = out_where_reg;
    assign result.count    = out_count_reg;
    assign result.is_empty = out_empty_reg;
    assign result.last     = out_last_reg;

endmodule

// File: src/sle_ctrl.sv
// List engine controller: operation sequencing state machine.
module sle_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_ready,
    input  sle_pkg::sle_stat_t stat,
    output sle_pkg::sle_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_UP    = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_CAP   = 4'd4;
    localparam logic [3:0] S_DN    = 4'd5;
    localparam logic [3:0] S_DEL   = 4'd6;
    localparam logic [3:0] S_ONE   = 4'd7;
    localparam logic [3:0] S_SCAN  = 4'd8;
    localparam logic [3:0] S_FEND  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       eval_reg, eval_next;
    logic       hit;

    assign op_ready = (state_reg == S_IDLE);
    assign hit      = eval_reg && stat.match;

    always_comb
    begin
        cmd        = '0;
        cmd.status = sle_pkg::ST_OK;
        state_next = state_reg;
        eval_next  = eval_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (stat.func)
                    sle_pkg::FN_CLEAR:
                    begin
                        if (stat.slot_free)
                        begin
                            cmd.clr_size = 1'b1;
                            cmd.emit     = 1'b1;
                            cmd.last     = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    sle_pkg::FN_INSERT:
                    begin
                        if (stat.ins_bad || stat.full)
                        begin
                            if (stat.slot_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.last   = 1'b1;
                                cmd.status = stat.ins_bad ? sle_pkg::ST_RANGE
                                                          : sle_pkg::ST_FULL;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.ptr_op = sle_pkg::PTR_SIZE;
                            state_next = S_UP;
                        end
                    end
                    sle_pkg::FN_DELETE, sle_pkg::FN_READ:
                    begin
                        if (stat.pos_bad)
                        begin
                            if (stat.slot_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.last   = 1'b1;
                                cmd.status = sle_pkg::ST_RANGE;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd_op  = sle_pkg::RD_POS;
                            state_next = S_CAP;
                        end
                    end
                    sle_pkg::FN_FIND, sle_pkg::FN_DUMP:
                    begin
                        cmd.ptr_op   = sle_pkg::PTR_ZERO;
                        cmd.hold_clr = 1'b1;
                        eval_next    = 1'b0;
                        state_next   = S_SCAN;
                    end
                    default:
                    begin
                        if (stat.slot_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.status = sle_pkg::ST_RANGE;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            // shift the tail up one entry, from the end down to the position
            S_UP:
            begin
                if (stat.up_done)
                    state_next = S_INS;
                else
                begin
                    cmd.rd_op  = sle_pkg::RD_UP;
                    cmd.ptr_op = sle_pkg::PTR_DEC;
                end
            end
            S_INS:
            begin
                if (stat.slot_free)
                begin
                    cmd.wr_val   = 1'b1;
                    cmd.inc_size = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = sle_pkg::EM_INS;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            // capture the addressed element
            S_CAP:
            begin
                cmd.cap = 1'b1;
                if (stat.func == sle_pkg::FN_DELETE)
                begin
                    cmd.ptr_op = sle_pkg::PTR_POS;
                    state_next = S_DN;
                end
                else
                    state_next = S_ONE;
            end
            // shift the tail down one entry over the removed element
            S_DN:
            begin
                if (stat.ptr_end)
                    state_next = S_DEL;
                else
                begin
                    cmd.rd_op  = sle_pkg::RD_DN;
                    cmd.ptr_op = sle_pkg::PTR_INC;
                end
            end
            S_DEL:
            begin
                if (stat.slot_free)
                begin
                    cmd.dec_size = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = sle_pkg::EM_HOLD;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ONE:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = sle_pkg::EM_HOLD;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            // walk the list; keep one match back so the final one can be marked last
            S_SCAN:
            begin
                if (!(hit && stat.hold_valid && !stat.slot_free))
                begin
                    if (hit && stat.hold_valid)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = sle_pkg::EM_HOLD;
                    end
                    cmd.hit = hit;
                    if (!stat.ptr_end)
                    begin
                        cmd.rd_op  = sle_pkg::RD_SCAN;
                        cmd.ptr_op = sle_pkg::PTR_INC;
                        eval_next  = 1'b1;
                    end
                    else
                        eval_next = 1'b0;
                    if (!eval_reg && stat.ptr_end)
                        state_next = S_FEND;
                end
            end
            S_FEND:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    if (stat.hold_valid)
                        cmd.emit_sel = sle_pkg::EM_HOLD;
                    else
                        cmd.status = sle_pkg::ST_NONE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eval_reg  <= eval_next;
        end
    end

endmodule

// File: src/sequential_list_engine.sv
// Top level of the sequential list engine: controller, datapath and checks.
//
//  channel  role     transfer                                  fields
//  op       sink     valid & ready at rising clk               func, position, value
//  result   source   valid & ready at rising clk               status, data, where,
//                                                              count, is_empty, last
//
// One operation at a time; op.ready is high only while idle, from the cycle after its last load.
// A result loads from the check state for clear and rejects; read and delete first capture the
// element, insert and delete then move each element behind the position, and find and dump
// walk every stored element before their last result loads.
// Reset clears the count; store contents stay undefined until written.
// An untaken result holds off the next load; the next operation may transfer in meanwhile.
module sequential_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sle_in_if.sink    op,
    sle_out_if.source result
);

    sle_pkg::sle_cmd_t  cmd;
    sle_pkg::sle_stat_t stat;
    logic               ready;

    assign op.ready = ready;

    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op.valid),
        .op_ready (ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .func     (op.func),
        .position (op.position),
        .value    (op.value),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

    // never overwrite a result that has not been taken
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.slot_free)
        else $error("result loaded over a pending result");

    // one operation at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (op.valid && op.ready) |=> !op.ready)
        else $error("engine ready right after an operation transfer");

    // rejected or empty results carry no element
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != sle_pkg::ST_OK) |->
            (result.data == '0 && result.where == '0))
        else $error("failing result carries an element");

    // count stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (int'(result.count) <= CAPACITY))
        else $error("element count beyond capacity");

endmodule

// File: dv/sequential_list_engine_test.sv
// Self-checking testbench for the list engine: directed table, random phases, scoreboard.
module sequential_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int LIST_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 370;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 40;
    localparam int VALUE_POOL   = 8;
    localparam int CHK_W        = sle_pkg::DATA_W + 1;

    // operation codes the engine does not define
    localparam logic [sle_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [sle_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd7;

    typedef struct packed {
        logic [sle_pkg::STAT_W-1:0]        status;
        logic signed [sle_pkg::DATA_W-1:0] data;
        logic [sle_pkg::POS_W-1:0]         where;
        logic [sle_pkg::COUNT_W-1:0]       count;
        logic                              is_empty;
        logic                              last;
    } list_result_t;

    typedef struct packed {
        logic [sle_pkg::FUNC_W-1:0]        func;
        logic [sle_pkg::POS_W-1:0]         position;
        logic signed [sle_pkg::DATA_W-1:0] value;
        logic                              typed;
        logic [sle_pkg::STAT_W-1:0]        status;
        logic signed [sle_pkg::DATA_W-1:0] data;
        logic [sle_pkg::POS_W-1:0]         where;
        logic [sle_pkg::COUNT_W-1:0]       count;
    } list_op_row_t;

    // Typed rows carry a single result that is obvious from the list contents;
    // the others are left to the predictor.
    localparam int DIRECTED_COUNT = 25;
    localparam list_op_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty list: every lookup misses
        '{sle_pkg::FN_READ, 6'd1, 32'sd0, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_DELETE, 6'd1, 32'sd0, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_DUMP, 6'd0, 32'sd0, 1'b1, sle_pkg::ST_NONE, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_FIND, 6'd0, 32'sd0, 1'b1, sle_pkg::ST_NONE, 32'sd0, 6'd0, 6'd0},
        // insert positions below 1 and beyond length plus one
        '{sle_pkg::FN_INSERT, 6'd0, 32'sd5, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_INSERT, 6'd2, 32'sd5, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd0},
        // value extremes at head and tail
        '{sle_pkg::FN_INSERT, 6'd1, 32'sh7fffffff, 1'b1, sle_pkg::ST_OK, 32'sh7fffffff,
          6'd1, 6'd1},
        '{sle_pkg::FN_INSERT, 6'd1, 32'sh80000000, 1'b1, sle_pkg::ST_OK, 32'sh80000000,
          6'd1, 6'd2},
        '{sle_pkg::FN_INSERT, 6'd3, -32'sd1, 1'b1, sle_pkg::ST_OK, -32'sd1, 6'd3, 6'd3},
        '{sle_pkg::FN_INSERT, 6'd2, 32'sd0, 1'b0, sle_pkg::ST_OK, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_INSERT, 6'd5, -32'sd1, 1'b0, sle_pkg::ST_OK, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_DUMP, 6'd0, 32'sd0, 1'b0, sle_pkg::ST_OK, 32'sd0, 6'd0, 6'd0},
        // several matches, then none
        '{sle_pkg::FN_FIND, 6'd0, -32'sd1, 1'b0, sle_pkg::ST_OK, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_FIND, 6'd0, 32'sd12345, 1'b1, sle_pkg::ST_NONE, 32'sd0, 6'd0, 6'd5},
        '{sle_pkg::FN_READ, 6'd63, 32'sd0, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd5},
        '{sle_pkg::FN_READ, 6'd0, 32'sd0, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd5},
        '{sle_pkg::FN_READ, 6'd3, 32'sd0, 1'b0, sle_pkg::ST_OK, 32'sd0, 6'd0, 6'd0},
        // delete the tail, then the head
        '{sle_pkg::FN_DELETE, 6'd5, 32'sd0, 1'b0, sle_pkg::ST_OK, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_DELETE, 6'd1, 32'sd0, 1'b0, sle_pkg::ST_OK, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_DELETE, 6'd6, 32'sd0, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd3},
        // unused operation codes
        '{FN_SPARE_A, 6'd63, -32'sd1, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd3},
        '{FN_SPARE_B, 6'd0, 32'sd0, 1'b1, sle_pkg::ST_RANGE, 32'sd0, 6'd0, 6'd3},
        '{sle_pkg::FN_CLEAR, 6'd0, 32'sd0, 1'b1, sle_pkg::ST_OK, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_DUMP, 6'd0, 32'sd0, 1'b1, sle_pkg::ST_NONE, 32'sd0, 6'd0, 6'd0},
        '{sle_pkg::FN_INSERT, 6'd1, 32'sd42, 1'b1, sle_pkg::ST_OK, 32'sd42, 6'd1, 6'd1}
    };

    logic clk;
    logic rst_n;

    sle_in_if  op_ch ();
    sle_out_if res_ch ();

    sequential_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch),
        .result(res_ch)
    );

    // shadow copy of the list
    logic signed [sle_pkg::DATA_W-1:0] list_vals [LIST_DEPTH];
    int                                list_len;

    list_result_t                      op_outcomes [$];
    list_result_t                      awaited_results [$];
    logic signed [sle_pkg::DATA_W-1:0] used_vals [$];

    int  fails;
    int  items_sent;
    int  results_seen;
    int  full_hits;
    int  ops_sent [8];
    int  quiet_cycles;
    bit  send_gaps;
    bit  take_gaps;
    bit  hold_results;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Append one result of the current operation, with the count after it.
    function automatic void record_outcome(logic [sle_pkg::STAT_W-1:0] st,
                                           logic signed [sle_pkg::DATA_W-1:0] d, int w);
        list_result_t res;
        res.status   = st;
        res.data     = d;
        res.where    = sle_pkg::POS_W'(w);
        res.count    = sle_pkg::COUNT_W'(list_len);
        res.is_empty = (list_len == 0);
        res.last     = 1'b0;
        op_outcomes.push_back(res);
        if (st == sle_pkg::ST_FULL)
            full_hits++;
    endfunction

    // Apply one operation to the shadow list and collect the results it causes.
    task automatic apply_list_op(input logic [sle_pkg::FUNC_W-1:0] f,
                                 input logic [sle_pkg::POS_W-1:0] p,
                                 input logic signed [sle_pkg::DATA_W-1:0] v);
        int                                pi;
        int                                i;
        logic signed [sle_pkg::DATA_W-1:0] gone;
        list_result_t                      tail;
        pi = int'(p);
        op_outcomes.delete();
        case (f)
            sle_pkg::FN_CLEAR:
            begin
                list_len = 0;
                record_outcome(sle_pkg::ST_OK, '0, 0);
            end
            sle_pkg::FN_INSERT:
            begin
                if (pi < 1 || pi > list_len + 1)
                    record_outcome(sle_pkg::ST_RANGE, '0, 0);
                else if (list_len >= LIST_DEPTH)
                    record_outcome(sle_pkg::ST_FULL, '0, 0);
                else
                begin
                    for (i = list_len; i >= pi; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[pi - 1] = v;
                    list_len++;
                    record_outcome(sle_pkg::ST_OK, v, pi);
                end
            end
            sle_pkg::FN_DELETE:
            begin
                if (pi < 1 || pi > list_len)
                    record_outcome(sle_pkg::ST_RANGE, '0, 0);
                else
                begin
                    gone = list_vals[pi - 1];
                    for (i = pi; i < list_len; i++)
                        list_vals[i - 1] = list_vals[i];
                    list_len--;
                    record_outcome(sle_pkg::ST_OK, gone, pi);
                end
            end
            sle_pkg::FN_READ:
            begin
                if (pi < 1 || pi > list_len)
                    record_outcome(sle_pkg::ST_RANGE, '0, 0);
                else
                    record_outcome(sle_pkg::ST_OK, list_vals[pi - 1], pi);
            end
            sle_pkg::FN_FIND:
            begin
                for (i = 0; i < list_len; i++)
                    if (list_vals[i] == v)
                        record_outcome(sle_pkg::ST_OK, v, i + 1);
                if (op_outcomes.size() == 0)
                    record_outcome(sle_pkg::ST_NONE, '0, 0);
            end
            sle_pkg::FN_DUMP:
            begin
                for (i = 0; i < list_len; i++)
                    record_outcome(sle_pkg::ST_OK, list_vals[i], i + 1);
                if (op_outcomes.size() == 0)
                    record_outcome(sle_pkg::ST_NONE, '0, 0);
            end
            default:
                record_outcome(sle_pkg::ST_RANGE, '0, 0);
        endcase
        // mark the final result of the operation
        tail = op_outcomes.pop_back();
        tail.last = 1'b1;
        op_outcomes.push_back(tail);
    endtask

    // Offer one operation, hold it until the transfer, then queue its results.
    task automatic send_op(input logic [sle_pkg::FUNC_W-1:0] f,
                           input logic [sle_pkg::POS_W-1:0] p,
                           input logic signed [sle_pkg::DATA_W-1:0] v,
                           input bit typed, input list_result_t typed_res);
        while (send_gaps && $urandom_range(99) < 15)
        begin
            op_ch.valid <= 1'b0;
            @(posedge clk);
        end
        op_ch.valid    <= 1'b1;
        op_ch.func     <= f;
        op_ch.position <= p;
        op_ch.value    <= v;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        apply_list_op(f, p, v);
        if (typed)
            awaited_results.push_back(typed_res);
        else
            foreach (op_outcomes[k])
                awaited_results.push_back(op_outcomes[k]);
        // keep a small pool of inserted values so finds hit repeatedly
        if (f == sle_pkg::FN_INSERT)
        begin
            used_vals.push_back(v);
            if (used_vals.size() > VALUE_POOL)
                void'(used_vals.pop_front());
        end
        ops_sent[f]++;
        items_sent++;
    endtask

    // Hold off new operations until every queued result has been taken.
    task automatic drain_results();
        op_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [sle_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 35 && used_vals.size() > 0)
            return used_vals[$urandom_range(used_vals.size() - 1)];
        if (r < 45)
        begin
            case ($urandom_range(3))
                0:       return 32'sd0;
                1:       return -32'sd1;
                2:       return 32'sh7fffffff;
                default: return 32'sh80000000;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly a legal position in 1..hi, sometimes anything the field holds.
    function automatic logic [sle_pkg::POS_W-1:0] pick_pos(int hi);
        if (hi >= 1 && $urandom_range(99) < 85)
            return sle_pkg::POS_W'($urandom_range(hi, 1));
        return sle_pkg::POS_W'($urandom_range(63));
    endfunction

    function automatic logic signed [sle_pkg::DATA_W-1:0] pick_search();
        if (list_len > 0 && $urandom_range(1) == 1)
            return list_vals[$urandom_range(list_len - 1)];
        return pick_value();
    endfunction

    function automatic void check_field(string name, logic signed [CHK_W-1:0] want,
                                        logic signed [CHK_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    // Compare one result transfer against the oldest expectation.
    task automatic take_result();
        list_result_t want;
        if (awaited_results.size() == 0)
        begin
            $error("result transfer with no result awaited");
            fails++;
            return;
        end
        want = awaited_results.pop_front();
        results_seen++;
        check_field("status", CHK_W'(want.status), CHK_W'(res_ch.status));
        check_field("data", CHK_W'(want.data), CHK_W'(res_ch.data));
        check_field("where", CHK_W'(want.where), CHK_W'(res_ch.where));
        check_field("count", CHK_W'(want.count), CHK_W'(res_ch.count));
        check_field("is_empty", CHK_W'(want.is_empty), CHK_W'(res_ch.is_empty));
        check_field("last", CHK_W'(want.last), CHK_W'(res_ch.last));
    endtask

    // Result side: check transfers, stall at random, and take one long hold when asked.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                take_result();
            if (hold_results)
            begin
                hold_results = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge clk);
            end
            res_ch.ready <= !take_gaps || ($urandom_range(99) >= 15);
        end
    end

    // Abort when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Reset, directed table, random phases, final report.
    initial
    begin
        int           phase_no;
        int           r;
        int           n;
        list_op_row_t row;
        list_result_t tres;

        clk            = 1'b0;
        rst_n          = 1'b0;
        op_ch.valid    = 1'b0;
        op_ch.func     = '0;
        op_ch.position = '0;
        op_ch.value    = '0;
        list_len       = 0;
        fails          = 0;
        items_sent     = 0;
        results_seen   = 0;
        full_hits      = 0;
        quiet_cycles   = 0;
        send_gaps      = 1'b1;
        take_gaps      = 1'b1;
        hold_results   = 1'b0;
        foreach (ops_sent[k])
            ops_sent[k] = 0;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int k = 0; k < DIRECTED_COUNT; k++)
        begin
            row  = DIRECTED_ROWS[k];
            tres = '{row.status, row.data, row.where, row.count, (row.count == 0), 1'b1};
            send_op(row.func, row.position, row.value, row.typed, tres);
        end
        drain_results();

        phase_no = 0;
        while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            // second phase runs under a long result stall, third with no idling
            if (phase_no == 1)
                hold_results = 1'b1;
            send_gaps = (phase_no != 2);
            take_gaps = (phase_no != 2);

            if (phase_no == 0 || (phase_no > 2 && r < 20))
            begin
                // fill to capacity, then push against the full store
                while (list_len < LIST_DEPTH)
                    send_op(sle_pkg::FN_INSERT, pick_pos(list_len + 1), pick_value(),
                            1'b0, '0);
                send_op(sle_pkg::FN_INSERT, sle_pkg::POS_W'($urandom_range(list_len + 1, 1)),
                        pick_value(), 1'b0, '0);
                send_op(sle_pkg::FN_INSERT, sle_pkg::POS_W'($urandom_range(63)), pick_value(),
                        1'b0, '0);
                send_op(sle_pkg::FN_DUMP, sle_pkg::POS_W'($urandom_range(63)), $urandom,
                        1'b0, '0);
                send_op(sle_pkg::FN_FIND, '0, pick_search(), 1'b0, '0);
                send_op(sle_pkg::FN_DELETE, sle_pkg::POS_W'(LIST_DEPTH), $urandom, 1'b0, '0);
            end
            else if (phase_no > 2 && r < 35)
            begin
                // empty the list by deletes, then probe it
                while (list_len > 0)
                    send_op(sle_pkg::FN_DELETE, pick_pos(list_len), $urandom, 1'b0, '0);
                send_op(sle_pkg::FN_READ, 6'd1, $urandom, 1'b0, '0);
                send_op(sle_pkg::FN_DUMP, '0, $urandom, 1'b0, '0);
            end
            else
            begin
                // mixed traffic, mostly well-formed
                n = $urandom_range(30, 12);
                repeat (n)
                begin
                    r = $urandom_range(99);
                    if (r < 35)
                        send_op(sle_pkg::FN_INSERT, pick_pos(list_len + 1), pick_value(),
                                1'b0, '0);
                    else if (r < 55)
                        send_op(sle_pkg::FN_DELETE, pick_pos(list_len), $urandom, 1'b0, '0);
                    else if (r < 68)
                        send_op(sle_pkg::FN_READ, pick_pos(list_len), $urandom, 1'b0, '0);
                    else if (r < 80)
                        send_op(sle_pkg::FN_FIND, sle_pkg::POS_W'($urandom_range(63)),
                                pick_search(), 1'b0, '0);
                    else if (r < 88)
                        send_op(sle_pkg::FN_DUMP, sle_pkg::POS_W'($urandom_range(63)),
                                $urandom, 1'b0, '0);
                    else if (r < 93)
                        send_op(sle_pkg::FN_CLEAR, sle_pkg::POS_W'($urandom_range(63)),
                                $urandom, 1'b0, '0);
                    else if (r < 96)
                        send_op($urandom_range(1) ? FN_SPARE_A : FN_SPARE_B,
                                sle_pkg::POS_W'($urandom_range(63)), $urandom, 1'b0, '0);
                    else
                        send_op(sle_pkg::FUNC_W'($urandom_range(7)),
                                sle_pkg::POS_W'($urandom_range(63)), $urandom, 1'b0, '0);
                end
            end
            drain_results();
            phase_no++;
        end

        send_gaps = 1'b1;
        take_gaps = 1'b1;
        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Ran %0d operations in %0d phases: %0d clear, %0d insert, %0d delete, %0d read,",
                 items_sent, phase_no, ops_sent[sle_pkg::FN_CLEAR],
                 ops_sent[sle_pkg::FN_INSERT], ops_sent[sle_pkg::FN_DELETE],
                 ops_sent[sle_pkg::FN_READ]);
        $display("%0d find, %0d dump, %0d unused codes; %0d results compared, %0d full rejects",
                 ops_sent[sle_pkg::FN_FIND], ops_sent[sle_pkg::FN_DUMP],
                 ops_sent[FN_SPARE_A] + ops_sent[FN_SPARE_B], results_seen, full_hits);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
